[sv/cba_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package cba_pkg;

  localparam int SLOT_COUNT   = 64;
  localparam int SLOT_BITS    = $clog2(SLOT_COUNT);
  localparam int LINK_BITS    = SLOT_BITS + 1;
  localparam int TAG_BITS     = 32;
  localparam int CONTENT_BITS = 64;

  // link value that marks the end of a chain
  localparam logic [LINK_BITS-1:0] NO_LINK = LINK_BITS'(SLOT_COUNT);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_FREE_SCAN = 7'b0000010,
    S_INS_WR    = 7'b0000100,
    S_INS_LINK  = 7'b0001000,
    S_TAG_SCAN  = 7'b0010000,
    S_WALK_CHK  = 7'b0100000,
    S_WALK_LD   = 7'b1000000
  } fsm_t;

endpackage
`default_nettype wire

[sv/chained_block_allocator_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Chained block allocator: a table of 64 slots, each with a file tag, a
// content word and a link to the next slot of the same file.
// Command channel: drive in_operation, in_file_tag and in_content_word with
// start high; the word is taken on a rising edge where busy is low. busy
// stays high until the result has been issued.
// Result channel: out_valid is high for exactly one cycle with status, slot
// index, freed count and occupancy; the receiver must take it then.
// Operation steps, scanning one slot at a time over the dual-port tag/link RAMs:
//   insert:        find the lowest free slot, write it, then link the previous
//                  inserted slot to it if the tags match; ST_FULL if none free
//   find:          one tag read per slot, pipelined, until a used slot matches
//   remove:        find, then walk the chain and free each linked slot
//   operation 3:   result on the cycle after accept
// busy drops on the cycle the result is shown, so a new command may be
// accepted back to back with the strobe.
// Reset clears all occupancy bits, the slot count and the previous-insert
// slot at once; no clearing pass is needed. Tag, content and link RAMs hold
// stale data that is never read for a free slot.
module chained_block_allocator_top
  import cba_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              in_operation,
  input  wire logic [TAG_BITS-1:0]     in_file_tag,
  input  wire logic [CONTENT_BITS-1:0] in_content_word,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [SLOT_BITS-1:0]         out_slot_index,
  output logic [LINK_BITS-1:0]         out_freed_count,
  output logic [LINK_BITS-1:0]         out_occupancy
);

  fsm_t                    state_r, state_nxt;
  logic [SLOT_COUNT-1:0]   used_r, used_nxt;
  logic [LINK_BITS-1:0]    count_r, count_nxt;
  logic [SLOT_BITS-1:0]    prev_r, prev_nxt;
  logic [1:0]              op_r, op_nxt;
  logic [TAG_BITS-1:0]     tag_r, tag_nxt;
  logic [CONTENT_BITS-1:0] content_r, content_nxt;
  logic [LINK_BITS-1:0]    scan_cnt_r, scan_cnt_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic [SLOT_BITS-1:0]    rd_idx_r, rd_idx_nxt;
  logic [SLOT_BITS-1:0]    cur_r, cur_nxt;
  logic [LINK_BITS-1:0]    id_r, id_nxt;
  logic [LINK_BITS-1:0]    freed_r, freed_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [1:0]              out_status_r, out_status_nxt;
  logic [SLOT_BITS-1:0]    out_slot_r, out_slot_nxt;
  logic [LINK_BITS-1:0]    out_freed_r, out_freed_nxt;
  logic [LINK_BITS-1:0]    out_occ_r, out_occ_nxt;

  logic                    tag_we;
  logic [SLOT_BITS-1:0]    tag_raddr;
  logic [TAG_BITS-1:0]     tag_q;
  logic                    next_we;
  logic [SLOT_BITS-1:0]    next_waddr;
  logic [LINK_BITS-1:0]    next_wdata;
  logic [LINK_BITS-1:0]    next_q;
  logic                    hit;

  cba_ram #(.WIDTH(TAG_BITS), .DEPTH(SLOT_COUNT)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (cur_r),
    .wdata (tag_r),
    .raddr (tag_raddr),
    .rdata (tag_q)
  );

  cba_ram #(.WIDTH(CONTENT_BITS), .DEPTH(SLOT_COUNT)) u_content_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (cur_r),
    .wdata (content_r),
    .raddr (cur_r),
    .rdata ()
  );

  cba_ram #(.WIDTH(LINK_BITS), .DEPTH(SLOT_COUNT)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (id_r[SLOT_BITS-1:0]),
    .rdata (next_q)
  );

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot_index  = out_slot_r;
  assign out_freed_count = out_freed_r;
  assign out_occupancy   = out_occ_r;

  assign tag_raddr = (state_r == S_TAG_SCAN) ? scan_cnt_r[SLOT_BITS-1:0] : prev_r;
  assign hit       = rd_vld_r && used_r[rd_idx_r] && (tag_q == tag_r);

  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    count_nxt      = count_r;
    prev_nxt       = prev_r;
    op_nxt         = op_r;
    tag_nxt        = tag_r;
    content_nxt    = content_r;
    scan_cnt_nxt   = scan_cnt_r;
    rd_vld_nxt     = rd_vld_r;
    rd_idx_nxt     = rd_idx_r;
    cur_nxt        = cur_r;
    id_nxt         = id_r;
    freed_nxt      = freed_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_freed_nxt  = out_freed_r;
    out_occ_nxt    = out_occ_r;
    tag_we         = 1'b0;
    next_we        = 1'b0;
    next_waddr     = cur_r;
    next_wdata     = NO_LINK;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt       = in_operation;
          tag_nxt      = in_file_tag;
          content_nxt  = in_content_word;
          scan_cnt_nxt = '0;
          rd_vld_nxt   = 1'b0;
          case (in_operation)
            OP_INSERT: state_nxt = S_FREE_SCAN;
            OP_REMOVE: state_nxt = S_TAG_SCAN;
            OP_FIND:   state_nxt = S_TAG_SCAN;
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_OK;
              out_slot_nxt   = '0;
              out_freed_nxt  = '0;
              out_occ_nxt    = count_r;
            end
          endcase
        end
      end

      S_FREE_SCAN: begin
        if (scan_cnt_r == LINK_BITS'(SLOT_COUNT)) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_FULL;
          out_slot_nxt   = '0;
          out_freed_nxt  = '0;
          out_occ_nxt    = count_r;
          state_nxt      = S_IDLE;
        end else if (!used_r[scan_cnt_r[SLOT_BITS-1:0]]) begin
          cur_nxt   = scan_cnt_r[SLOT_BITS-1:0];
          state_nxt = S_INS_WR;
        end else begin
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end
      end

      S_INS_WR: begin
        // write the new slot while the tag of the previous slot is read
        tag_we          = 1'b1;
        next_we         = 1'b1;
        used_nxt[cur_r] = 1'b1;
        count_nxt       = count_r + 1'b1;
        if (count_r == '0) begin
          prev_nxt = '0;
        end
        state_nxt = S_INS_LINK;
      end

      S_INS_LINK: begin
        // prev_r equal to cur_r: slot reused, leave links alone
        if (prev_r != cur_r && used_r[prev_r]) begin
          next_we    = 1'b1;
          next_waddr = prev_r;
          next_wdata = (tag_q == tag_r) ? {1'b0, cur_r} : NO_LINK;
        end
        prev_nxt       = cur_r;
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        out_slot_nxt   = cur_r;
        out_freed_nxt  = '0;
        out_occ_nxt    = count_r;
        state_nxt      = S_IDLE;
      end

      S_TAG_SCAN: begin
        if (hit) begin
          cur_nxt = rd_idx_r;
          if (op_r == OP_FIND) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_OK;
            out_slot_nxt   = rd_idx_r;
            out_freed_nxt  = '0;
            out_occ_nxt    = count_r;
            state_nxt      = S_IDLE;
          end else begin
            id_nxt    = {1'b0, rd_idx_r};
            freed_nxt = '0;
            state_nxt = S_WALK_CHK;
          end
        end else if (scan_cnt_r == LINK_BITS'(SLOT_COUNT)) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_NOT_FOUND;
          out_slot_nxt   = '0;
          out_freed_nxt  = '0;
          out_occ_nxt    = count_r;
          state_nxt      = S_IDLE;
        end else begin
          // issue next tag read, compare it next cycle
          rd_vld_nxt   = 1'b1;
          rd_idx_nxt   = scan_cnt_r[SLOT_BITS-1:0];
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end
      end

      S_WALK_CHK: begin
        if (id_r < LINK_BITS'(SLOT_COUNT) && used_r[id_r[SLOT_BITS-1:0]]) begin
          used_nxt[id_r[SLOT_BITS-1:0]] = 1'b0;
          count_nxt = count_r - 1'b1;
          freed_nxt = freed_r + 1'b1;
          state_nxt = S_WALK_LD;
        end else begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_slot_nxt   = cur_r;
          out_freed_nxt  = freed_r;
          out_occ_nxt    = count_r;
          state_nxt      = S_IDLE;
        end
      end

      S_WALK_LD: begin
        // advance along the chain
        id_nxt    = next_q;
        state_nxt = S_WALK_CHK;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      count_r     <= '0;
      prev_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      count_r     <= count_nxt;
      prev_r      <= prev_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    tag_r        <= tag_nxt;
    content_r    <= content_nxt;
    scan_cnt_r   <= scan_cnt_nxt;
    rd_idx_r     <= rd_idx_nxt;
    cur_r        <= cur_nxt;
    id_r         <= id_nxt;
    freed_r      <= freed_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_freed_r  <= out_freed_nxt;
    out_occ_r    <= out_occ_nxt;
  end

endmodule
`default_nettype wire

[sv/cba_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module cba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire
